// ===== design/ffpsa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ffpsa_pkg;

  // default sizing of the page table
  localparam int unsigned DEF_PAGE_BYTES    = 4096;
  localparam int unsigned DEF_TABLE_ENTRIES = 64;

  // field widths
  localparam int unsigned PAGE_ID_W = 32;
  localparam int unsigned FCOUNT_W  = 13;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned OFFSET_W  = 13;
  localparam int unsigned STATUS_W  = 3;

  // wide enough for any page size up to 65536 and any 16-bit request
  localparam int unsigned VAL_W = 17;

  // stream word widths
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 64;

  // item kinds
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_PLACED   = 3'd0,
    ST_NEWPAGE  = 3'd1,
    ST_TOOLARGE = 3'd2,
    ST_FULL     = 3'd3,
    ST_LOADED   = 3'd4
  } status_e;

  typedef struct packed {
    logic                 func;
    logic [PAGE_ID_W-1:0] page_id;
    logic [FCOUNT_W-1:0]  free_count;
    logic [SIZE_W-1:0]    tuple_size;
    logic [PAGE_ID_W-1:0] spare_page;
  } in_item_t;

  typedef struct packed {
    logic [PAGE_ID_W-1:0] row_page;
    logic [OFFSET_W-1:0]  row_offset;
    logic [OFFSET_W-1:0]  row_length;
    status_e              status;
  } res_t;

  // table write request
  typedef struct packed {
    logic                 we_page;
    logic                 we_free;
    logic [PAGE_ID_W-1:0] page;
    logic [VAL_W-1:0]     free;
  } tbl_wr_t;

endpackage

`default_nettype wire

// ===== design/ffpsa_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffpsa_table #(
  parameter int unsigned ENTRIES = ffpsa_pkg::DEF_TABLE_ENTRIES,
  parameter int unsigned FREE_W  = 13,
  parameter int unsigned IDX_W   = 6
) (
  input  wire logic                           clk_i,
  input  wire ffpsa_pkg::tbl_wr_t             wr_i,
  input  wire logic [IDX_W-1:0]               waddr_i,
  input  wire logic [IDX_W-1:0]               raddr_i,
  output logic [ffpsa_pkg::PAGE_ID_W-1:0]     rpage_o,
  output logic [FREE_W-1:0]                   rfree_o
);
  import ffpsa_pkg::*;

  logic [PAGE_ID_W-1:0] page_mem [ENTRIES];
  logic [FREE_W-1:0]    free_mem [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (wr_i.we_page) begin
      page_mem[waddr_i] <= wr_i.page;
    end
    if (wr_i.we_free) begin
      free_mem[waddr_i] <= wr_i.free[FREE_W-1:0];
    end
    rpage_o <= page_mem[raddr_i];
    rfree_o <= free_mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/ffpsa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffpsa_ctrl #(
  parameter int unsigned PAGE_BYTES    = ffpsa_pkg::DEF_PAGE_BYTES,
  parameter int unsigned TABLE_ENTRIES = ffpsa_pkg::DEF_TABLE_ENTRIES,
  parameter int unsigned FREE_W        = 13,
  parameter int unsigned IDX_W         = 6,
  parameter int unsigned CNT_W         = 7
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire ffpsa_pkg::in_item_t         in_item_i,
  output logic                             res_valid_o,
  input  wire logic                        res_ready_i,
  output ffpsa_pkg::res_t                  res_o,
  output ffpsa_pkg::tbl_wr_t               wr_o,
  output logic [IDX_W-1:0]                 waddr_o,
  output logic [IDX_W-1:0]                 raddr_o,
  input  wire logic [ffpsa_pkg::PAGE_ID_W-1:0] rpage_i,
  input  wire logic [FREE_W-1:0]           rfree_i
);
  import ffpsa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  in_item_t         item_q, item_d;
  res_t             res_q, res_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  logic [VAL_W-1:0] page_w, size_w, fc_w, fc_sat, rfree_w;
  logic             full, fit, last;

  assign page_w  = VAL_W'(PAGE_BYTES);
  assign size_w  = VAL_W'(item_q.tuple_size);
  assign fc_w    = VAL_W'(item_q.free_count);
  assign fc_sat  = (fc_w > page_w) ? page_w : fc_w;
  assign rfree_w = VAL_W'(rfree_i);
  assign full    = (cnt_q == CNT_W'(TABLE_ENTRIES));
  assign fit     = (rfree_w >= size_w);
  assign last    = (CNT_W'(idx_q) == (cnt_q - CNT_W'(1)));

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = res_q;

  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    res_d   = res_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    wr_o    = '0;
    waddr_o = cnt_q[IDX_W-1:0];
    raddr_o = idx_q + IDX_W'(1);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_d   = '{row_page: '0, row_offset: '0, row_length: '0, status: ST_FULL};
        state_d = S_RESP;
        raddr_o = '0;
        if (item_q.func == FUNC_LOAD) begin
          if (!full) begin
            wr_o.we_page  = 1'b1;
            wr_o.we_free  = 1'b1;
            wr_o.page     = item_q.page_id;
            wr_o.free     = fc_sat;
            cnt_d         = cnt_q + CNT_W'(1);
            res_d.status  = ST_LOADED;
          end
        end else if (size_w > page_w) begin
          res_d.status = ST_TOOLARGE;
        end else if (cnt_q == '0) begin
          // empty table: first insert opens a new page
          wr_o.we_page = 1'b1;
          wr_o.we_free = 1'b1;
          wr_o.page    = item_q.spare_page;
          wr_o.free    = page_w - size_w;
          cnt_d        = cnt_q + CNT_W'(1);
          res_d        = '{row_page:   item_q.spare_page,
                           row_offset: '0,
                           row_length: item_q.tuple_size[OFFSET_W-1:0],
                           status:     ST_NEWPAGE};
        end else begin
          idx_d   = '0;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        // read data holds entry idx_q, next address already issued
        if (fit) begin
          wr_o.we_free = 1'b1;
          wr_o.free    = rfree_w - size_w;
          waddr_o      = idx_q;
          res_d        = '{row_page:   rpage_i,
                           row_offset: OFFSET_W'(page_w - rfree_w),
                           row_length: item_q.tuple_size[OFFSET_W-1:0],
                           status:     ST_PLACED};
          state_d      = S_RESP;
        end else if (last) begin
          state_d = S_RESP;
          if (full) begin
            res_d = '{row_page: '0, row_offset: '0, row_length: '0, status: ST_FULL};
          end else begin
            wr_o.we_page = 1'b1;
            wr_o.we_free = 1'b1;
            wr_o.page    = item_q.spare_page;
            wr_o.free    = page_w - size_w;
            cnt_d        = cnt_q + CNT_W'(1);
            res_d        = '{row_page:   item_q.spare_page,
                             row_offset: '0,
                             row_length: item_q.tuple_size[OFFSET_W-1:0],
                             status:     ST_NEWPAGE};
          end
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    idx_q  <= idx_d;
  end

endmodule

`default_nettype wire

// ===== design/first_fit_page_space_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// a load word passes through the EXEC and RESP states into the output register; an insert
//   of a fitting tuple into a non-empty table first scans entries in SCAN from entry 0
//   until one fits or the last is reached; the sequencer takes one word at a time, and the
//   single table read port scans one entry per cycle
// reset: entry count and control state clear at once; the page table is not cleared,
//   and the contents of entries at or above the entry count are never used

module first_fit_page_space_allocator #(
  parameter int unsigned PAGE_BYTES    = ffpsa_pkg::DEF_PAGE_BYTES,
  parameter int unsigned TABLE_ENTRIES = ffpsa_pkg::DEF_TABLE_ENTRIES
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // slave side
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // page_id[31:0], free_count[44:32], tuple_size[60:45], spare_page[92:61], zero pad
  input  wire logic [ffpsa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // func: 0 load directory entry, 1 insert
  input  wire logic                              s_axis_tuser,
  // master side
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // row_page[31:0], row_offset[44:32], row_length[57:45], zero pad
  output logic [ffpsa_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // status
  output logic [ffpsa_pkg::STATUS_W-1:0]         m_axis_tuser
);
  import ffpsa_pkg::*;

  // table geometry follows from the parameters
  localparam int unsigned FREE_W = $clog2(PAGE_BYTES + 1);
  localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W  = $clog2(TABLE_ENTRIES + 1);

  in_item_t             in_item;
  res_t                 res;
  logic                 res_valid, res_ready;
  tbl_wr_t              tbl_wr;
  logic [IDX_W-1:0]     waddr, raddr;
  logic [PAGE_ID_W-1:0] rpage;
  logic [FREE_W-1:0]    rfree;

  // unpack the input word
  assign in_item.func       = s_axis_tuser;
  assign in_item.page_id    = s_axis_tdata[31:0];
  assign in_item.free_count = s_axis_tdata[44:32];
  assign in_item.tuple_size = s_axis_tdata[60:45];
  assign in_item.spare_page = s_axis_tdata[92:61];

  ffpsa_ctrl #(
    .PAGE_BYTES    (PAGE_BYTES),
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .FREE_W        (FREE_W),
    .IDX_W         (IDX_W),
    .CNT_W         (CNT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .wr_o        (tbl_wr),
    .waddr_o     (waddr),
    .raddr_o     (raddr),
    .rpage_i     (rpage),
    .rfree_i     (rfree)
  );

  // page table: one write port, one registered read port
  ffpsa_table #(
    .ENTRIES (TABLE_ENTRIES),
    .FREE_W  (FREE_W),
    .IDX_W   (IDX_W)
  ) u_table (
    .clk_i   (clk_i),
    .wr_i    (tbl_wr),
    .waddr_i (waddr),
    .raddr_i (raddr),
    .rpage_o (rpage),
    .rfree_o (rfree)
  );

  // output register: the sequencer can take the next word while a result waits here
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [STATUS_W-1:0]   out_user_q;

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= {6'b0, res.row_length, res.row_offset, res.row_page};
      out_user_q <= res.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire
